FILE: design/tgr_pkg.sv
`timescale 1ns / 1ps

package tgr_pkg;

    localparam int GLYPH_COUNT = 256;
    localparam int GLYPH_ROWS  = 8;
    localparam int GLYPH_COLS  = 8;

    localparam logic       OP_LOAD  = 1'b0;
    localparam logic       OP_PRINT = 1'b1;

    localparam logic [7:0] CHAR_LF = 8'd10;
    localparam logic [7:0] CHAR_CR = 8'd13;

    localparam logic [10:0] CURSOR_X_MAX = 11'd2047;
    localparam logic [11:0] CURSOR_Y_MAX = 12'd4095;

    localparam logic [1:0] REG_GLYPH_WIDTH   = 2'd0;
    localparam logic [1:0] REG_GLYPH_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_GLYPH_SPACING = 2'd2;

    typedef struct packed {
        logic        operation;
        logic        start_of_string;
        logic [9:0]  origin_x;
        logic [11:0] origin_y;
        logic [7:0]  char_code;
        logic [2:0]  glyph_row;
        logic [7:0]  row_bits;
        logic [7:0]  pixel_color;
    } t_item;

    typedef struct packed {
        logic [9:0]  pixel_x;
        logic [11:0] pixel_y;
        logic [21:0] pixel_index;
        logic [7:0]  color;
        logic        last;
    } t_pix;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_FLUSH,
        ST_DRAW
    } t_state;

endpackage

FILE: design/tgr_if.sv
`timescale 1ns / 1ps

interface tgr_in_if import tgr_pkg::*; ();
    logic  valid;
    logic  ready;
    t_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tgr_out_if import tgr_pkg::*; ();
    logic valid;
    logic ready;
    t_pix data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/text_glyph_pixel_renderer.sv
`timescale 1ns / 1ps

// channel   direction  beat
// i_item    in         one glyph row load or one character to print
// o_pix     out        one pixel write (x, y, linear index, colour, last)
// apb       in/out     glyph width, height and spacing registers
//
// loads, line feeds, carriage returns and clipped characters are done in the idle state
// a drawn character reads ROWS_PER_GLYPH rows from the glyph memory (one write port,
// one read port), one a cycle, then a flush state, then one pixel per cycle while
// o_pix is not stalled, stepping over empty rows; a glyph with no set bits draws none
// reset clears cursor, latched origin x and colour; the glyph memory is not cleared
// a stalled o_pix holds its beat and pauses drawing; once the last beat of a
// character is held the next item is taken

module text_glyph_pixel_renderer
    import tgr_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 256,
    parameter int ROWS_PER_GLYPH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tgr_in_if.sink      i_item,
    tgr_out_if.source   o_pix,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int          GlyphDepth = GLYPH_COUNT * GLYPH_ROWS;
    localparam logic [2:0]  LastRow    = 3'(ROWS_PER_GLYPH - 1);
    localparam logic [21:0] ScCols     = 22'(SCREEN_COLUMNS);
    localparam logic [11:0] ScEdge     = 12'(SCREEN_COLUMNS);

    // configuration
    logic [3:0] r_glyph_width, r_glyph_height, r_glyph_spacing;
    logic       cfg_wr;

    // glyph memory
    logic [7:0]  r_glyph_mem [GlyphDepth];
    logic [7:0]  r_rd_data;
    logic        mem_we;
    logic [10:0] mem_waddr;
    logic [10:0] mem_raddr;

    // control and state
    t_state      r_state, n_state;
    logic [10:0] r_cursor_x, n_cursor_x;
    logic [11:0] r_cursor_y, n_cursor_y;
    logic [9:0]  r_lox, n_lox;
    logic [7:0]  r_color, n_color;
    logic [7:0]  r_char, n_char;
    logic [2:0]  r_frow, n_frow;
    logic        r_rd_pend, n_rd_pend;
    logic [2:0]  r_rd_idx, n_rd_idx;
    logic [63:0] r_bits, n_bits;
    logic [2:0]  r_row, n_row;
    logic [21:0] r_row_base, n_row_base;
    logic        r_out_valid, n_out_valid;
    t_pix        r_pix, n_pix;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[3:2])
            REG_GLYPH_WIDTH:   prdata = {28'd0, r_glyph_width};
            REG_GLYPH_HEIGHT:  prdata = {28'd0, r_glyph_height};
            REG_GLYPH_SPACING: prdata = {28'd0, r_glyph_spacing};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_width   <= 4'd8;
            r_glyph_height  <= 4'd8;
            r_glyph_spacing <= 4'd1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_GLYPH_WIDTH:   r_glyph_width   <= pwdata[3:0];
                REG_GLYPH_HEIGHT:  r_glyph_height  <= pwdata[3:0];
                REG_GLYPH_SPACING: r_glyph_spacing <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    assign mem_waddr = {i_item.data.char_code, i_item.data.glyph_row};
    assign mem_raddr = {r_char, r_frow};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_glyph_mem[mem_waddr] <= i_item.data.row_bits;
        end
        r_rd_data <= r_glyph_mem[mem_raddr];
    end

    assign i_item.ready = (r_state == ST_IDLE);
    assign o_pix.valid  = r_out_valid;
    assign o_pix.data   = r_pix;

    always_comb begin
        logic        accept;
        logic [10:0] cx0;
        logic [11:0] cy0;
        logic [9:0]  lox0;
        logic [4:0]  adv_x;
        logic [4:0]  adv_y;
        logic [11:0] cx_sum;
        logic [12:0] cy_sum;
        logic [10:0] cx_adv;
        logic [10:0] cx_new;
        logic [11:0] cy_new;
        logic        is_ctrl;
        logic        drawable;
        logic [7:0]  cur;
        logic [7:0]  cur_rest;
        logic [63:0] rest;
        logic [63:0] higher;
        logic [2:0]  lsb;
        logic        slot_free;
        logic [10:0] px;

        n_state     = r_state;
        n_cursor_x  = r_cursor_x;
        n_cursor_y  = r_cursor_y;
        n_lox       = r_lox;
        n_color     = r_color;
        n_char      = r_char;
        n_frow      = r_frow;
        n_rd_pend   = 1'b0;
        n_rd_idx    = r_frow;
        n_bits      = r_bits;
        n_row       = r_row;
        n_row_base  = r_row_base;
        n_pix       = r_pix;
        mem_we      = 1'b0;

        slot_free   = !r_out_valid || o_pix.ready;
        n_out_valid = r_out_valid && !o_pix.ready;

        accept   = i_item.valid && (r_state == ST_IDLE);
        cx0      = i_item.data.start_of_string ? {1'b0, i_item.data.origin_x} : r_cursor_x;
        cy0      = i_item.data.start_of_string ? i_item.data.origin_y : r_cursor_y;
        lox0     = i_item.data.start_of_string ? i_item.data.origin_x : r_lox;
        adv_x    = {1'b0, r_glyph_width} + {1'b0, r_glyph_spacing};
        adv_y    = {1'b0, r_glyph_height} + {1'b0, r_glyph_spacing};
        cx_sum   = {1'b0, cx0} + {7'd0, adv_x};
        cy_sum   = {1'b0, cy0} + {8'd0, adv_y};
        cx_adv   = cx_sum[11] ? CURSOR_X_MAX : cx_sum[10:0];
        is_ctrl  = (i_item.data.char_code == CHAR_LF) || (i_item.data.char_code == CHAR_CR);
        cx_new   = is_ctrl ? {1'b0, lox0} : cx_adv;
        cy_new   = cy0;
        if (i_item.data.char_code == CHAR_LF) begin
            cy_new = cy_sum[12] ? CURSOR_Y_MAX : cy_sum[11:0];
        end
        drawable = !is_ctrl && ({1'b0, cx_new} < (ScEdge - {8'd0, r_glyph_width}));

        cur      = r_bits[{r_row, 3'b000} +: 8];
        cur_rest = cur & (cur - 8'd1);
        rest     = r_bits >> {r_row, 3'b000};
        higher   = r_bits >> ({1'b0, r_row, 3'b000} + 7'd8);
        lsb      = 3'd0;
        for (int c = GLYPH_COLS - 1; c >= 0; c--) begin
            if (cur[c]) begin
                lsb = 3'(c);
            end
        end
        px = r_cursor_x + {8'd0, lsb};

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_item.data.operation == OP_LOAD) begin
                        mem_we = 1'b1;
                    end else begin
                        n_lox      = lox0;
                        n_cursor_x = cx_new;
                        n_cursor_y = cy_new;
                        if (i_item.data.start_of_string) begin
                            n_color = i_item.data.pixel_color;
                        end
                        if (drawable) begin
                            n_char  = i_item.data.char_code;
                            n_frow  = 3'd0;
                            n_bits  = 64'd0;
                            n_row   = 3'd0;
                            n_state = ST_FETCH;
                        end
                    end
                end
            end
            ST_FETCH: begin
                n_rd_pend = 1'b1;
                n_rd_idx  = r_frow;
                if (r_frow == 3'd0) begin
                    n_row_base = ({10'd0, r_cursor_y} * ScCols) + {11'd0, r_cursor_x};
                end
                if (r_frow == LastRow) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_frow = r_frow + 3'd1;
                end
            end
            ST_FLUSH: begin
                n_state = ST_DRAW;
            end
            ST_DRAW: begin
                if (rest == 64'd0) begin
                    n_state = ST_IDLE;
                end else if (cur == 8'd0) begin
                    n_row      = r_row + 3'd1;
                    n_row_base = r_row_base + ScCols;
                end else if (slot_free) begin
                    n_out_valid       = 1'b1;
                    n_pix.pixel_x     = px[9:0];
                    n_pix.pixel_y     = r_cursor_y + {9'd0, r_row};
                    n_pix.pixel_index = r_row_base + {19'd0, lsb};
                    n_pix.color       = r_color;
                    n_pix.last        = (cur_rest == 8'd0) && (higher == 64'd0);
                    n_bits[{r_row, lsb}] = 1'b0;
                    if (n_pix.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // row data arrives in the cycle after its read was issued
        if (r_rd_pend) begin
            n_bits[{r_rd_idx, 3'b000} +: 8] = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cursor_x  <= 11'd0;
            r_cursor_y  <= 12'd0;
            r_lox       <= 10'd0;
            r_color     <= 8'd0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor_x  <= n_cursor_x;
            r_cursor_y  <= n_cursor_y;
            r_lox       <= n_lox;
            r_color     <= n_color;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char     <= n_char;
        r_frow     <= n_frow;
        r_rd_idx   <= n_rd_idx;
        r_bits     <= n_bits;
        r_row      <= n_row;
        r_row_base <= n_row_base;
        r_pix      <= n_pix;
    end

endmodule

FILE: test/text_glyph_pixel_checker.sv
`timescale 1ns / 1ps

module text_glyph_pixel_checker
    import tgr_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 256,
    parameter int ROWS_PER_GLYPH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tgr_in_if           i_item,
    tgr_out_if          i_pix,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending
);

    logic [7:0]  font_mem [GLYPH_COUNT*GLYPH_ROWS];
    logic [10:0] cur_x;
    logic [11:0] cur_y;
    logic [9:0]  org_x;
    logic [7:0]  ink;
    logic [3:0]  cell_w;
    logic [3:0]  cell_h;
    logic [3:0]  gap;
    t_pix        pix_q [$];
    int          errors;

    function automatic int sat_sum(int a, int b, int lim);
        int s;
        s = a + b;
        return (s > lim) ? lim : s;
    endfunction

    task automatic render_glyph(input t_item it);
        t_pix       glyph_pix [GLYPH_ROWS*GLYPH_COLS];
        int         n;
        int         px;
        int         py;
        logic [7:0] bits;
        n = 0;
        if (it.operation == OP_LOAD) begin
            font_mem[{it.char_code, it.glyph_row}] = it.row_bits;
            return;
        end
        if (it.start_of_string) begin
            org_x = it.origin_x;
            ink   = it.pixel_color;
            cur_x = {1'b0, it.origin_x};
            cur_y = it.origin_y;
        end
        cur_x = 11'(sat_sum(int'(cur_x), int'(cell_w) + int'(gap), int'(CURSOR_X_MAX)));
        if (it.char_code == CHAR_LF) begin
            cur_y = 12'(sat_sum(int'(cur_y), int'(cell_h) + int'(gap), int'(CURSOR_Y_MAX)));
            cur_x = {1'b0, org_x};
            return;
        end
        if (it.char_code == CHAR_CR) begin
            cur_x = {1'b0, org_x};
            return;
        end
        if (!(int'(cur_x) < SCREEN_COLUMNS - int'(cell_w))) return;
        for (int r = 0; r < ROWS_PER_GLYPH && r < GLYPH_ROWS; r++) begin
            bits = font_mem[{it.char_code, 3'(r)}];
            for (int c = 0; c < GLYPH_COLS; c++) begin
                if (bits[c]) begin
                    px = int'(cur_x) + c;
                    py = int'(cur_y) + r;
                    glyph_pix[n].pixel_x     = 10'(px);
                    glyph_pix[n].pixel_y     = 12'(py);
                    glyph_pix[n].pixel_index = 22'(px + py * SCREEN_COLUMNS);
                    glyph_pix[n].color       = ink;
                    glyph_pix[n].last        = 1'b0;
                    n++;
                end
            end
        end
        if (n > 0) glyph_pix[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) pix_q.push_back(glyph_pix[k]);
    endtask

    always @(posedge i_clk) begin
        t_pix want;
        t_pix got;
        if (!i_rst_n) begin
            cur_x  = '0;
            cur_y  = '0;
            org_x  = '0;
            ink    = '0;
            cell_w = 4'd8;
            cell_h = 4'd8;
            gap    = 4'd1;
            errors = 0;
            pix_q.delete();
        end else begin
            if (i_pix.valid && i_pix.ready) begin
                got = i_pix.data;
                if (pix_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected pixel beat x=%0d y=%0d idx=%0d colour=%0d",
                             $time, got.pixel_x, got.pixel_y, got.pixel_index, got.color);
                end else begin
                    want = pix_q.pop_front();
                    if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
                        got.pixel_index !== want.pixel_index || got.color !== want.color ||
                        got.last !== want.last) begin
                        errors++;
                        $display("%0t: pixel mismatch expected x=%0d y=%0d idx=%0d c=%0d l=%0b",
                                 $time, want.pixel_x, want.pixel_y, want.pixel_index,
                                 want.color, want.last);
                        $display("%0t: pixel mismatch actual   x=%0d y=%0d idx=%0d c=%0d l=%0b",
                                 $time, got.pixel_x, got.pixel_y, got.pixel_index,
                                 got.color, got.last);
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_GLYPH_WIDTH: begin
                        cell_w = pwdata[3:0];
                    end
                    REG_GLYPH_HEIGHT: begin
                        cell_h = pwdata[3:0];
                    end
                    REG_GLYPH_SPACING: begin
                        gap = pwdata[3:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_item.valid && i_item.ready) render_glyph(i_item.data);
        end
        o_errors  <= errors;
        o_pending <= pix_q.size();
    end

endmodule

FILE: test/text_glyph_pixel_renderer_tb.sv
`timescale 1ns / 1ps

module text_glyph_pixel_renderer_tb;
    import tgr_pkg::*;

    localparam int SCREEN_COLUMNS = 256;
    localparam int ROWS_PER_GLYPH = 8;
    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int PHASE_ITEMS    = 83;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          src_idle = 0;
    int          sink_stall = 0;
    logic [7:0]  rows_loaded [GLYPH_COUNT];
    logic [7:0]  printable [$];

    tgr_in_if  item_ch ();
    tgr_out_if pix_ch ();

    always #5 i_clk = ~i_clk;

    text_glyph_pixel_renderer #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .ROWS_PER_GLYPH (ROWS_PER_GLYPH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_pix   (pix_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    text_glyph_pixel_checker #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .ROWS_PER_GLYPH (ROWS_PER_GLYPH)
    ) pixel_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item_ch),
        .i_pix     (pix_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        pix_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            pix_ch.ready <= ($urandom_range(99) >= sink_stall);
        end
    end

    function automatic t_item random_item();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(t_item)-1:0];
    endfunction

    function automatic logic [7:0] pick_char();
        return printable[$urandom_range(printable.size() - 1)];
    endfunction

    task automatic put_item(input t_item it);
        while ($urandom_range(99) < src_idle) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    task automatic load_row(input logic [7:0] ch, input logic [2:0] row, input logic [7:0] bits);
        t_item it;
        it           = random_item();
        it.operation = OP_LOAD;
        it.char_code = ch;
        it.glyph_row = row;
        it.row_bits  = bits;
        put_item(it);
        if (rows_loaded[ch] != 8'hFF) begin
            rows_loaded[ch][row] = 1'b1;
            if (rows_loaded[ch] == 8'hFF) printable.push_back(ch);
        end
    endtask

    task automatic print_char(input logic sos, input logic [9:0] ox, input logic [11:0] oy,
                              input logic [7:0] ch, input logic [7:0] colour);
        t_item it;
        it                 = random_item();
        it.operation       = OP_PRINT;
        it.start_of_string = sos;
        it.char_code       = ch;
        if (sos) begin
            it.origin_x    = ox;
            it.origin_y    = oy;
            it.pixel_color = colour;
        end
        put_item(it);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {28'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_phase(input int n);
        int         left;
        int         len;
        int         roll;
        logic       sos;
        logic [9:0] ox;
        logic [11:0] oy;
        logic [7:0] colour;
        logic [7:0] ch;
        left = n;
        while (left > 0) begin
            if ($urandom_range(99) < 15) begin
                ch = ($urandom_range(3) == 0) ? 8'($urandom) : pick_char();
                load_row(ch, 3'($urandom), 8'($urandom));
                left--;
            end else begin
                len    = $urandom_range(1, 12);
                sos    = ($urandom_range(99) < 85);
                ox     = ($urandom_range(99) < 80) ? 10'($urandom_range(0, 200)) : 10'($urandom);
                oy     = 12'($urandom);
                colour = 8'($urandom);
                for (int k = 0; k < len && left > 0; k++) begin
                    roll = $urandom_range(99);
                    if (roll < 8) ch = CHAR_LF;
                    else if (roll < 14) ch = CHAR_CR;
                    else ch = pick_char();
                    print_char(sos && k == 0, ox, oy, ch, colour);
                    left--;
                end
            end
        end
    endtask

    initial begin
        logic [7:0] font [8];
        logic [7:0] bits;
        logic [3:0] cfg_w;
        logic [3:0] cfg_h;
        logic [3:0] cfg_s;
        i_rst_n       <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        foreach (rows_loaded[i]) rows_loaded[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // small font: full, diagonal, empty, random glyphs
        font = '{8'h00, 8'hFF, 8'hAA, 8'h55, CHAR_LF, 8'($urandom), 8'($urandom), 8'($urandom)};
        foreach (font[g]) begin
            for (int r = 0; r < GLYPH_ROWS; r++) begin
                case (font[g])
                    8'h00: begin
                        bits = 8'hFF;
                    end
                    8'hFF: begin
                        bits = 8'h01 << r;
                    end
                    8'hAA: begin
                        bits = 8'h00;
                    end
                    default: begin
                        bits = 8'($urandom);
                    end
                endcase
                load_row(font[g], 3'(r), bits);
            end
        end

        print_char(1'b1, 10'd0, 12'd0, 8'h00, 8'h00);
        print_char(1'b0, 10'd0, 12'd0, 8'hFF, 8'h00);
        print_char(1'b0, 10'd0, 12'd0, 8'hAA, 8'h00);
        print_char(1'b0, 10'd0, 12'd0, CHAR_LF, 8'h00);
        print_char(1'b0, 10'd0, 12'd0, 8'h00, 8'h00);
        print_char(1'b0, 10'd0, 12'd0, CHAR_CR, 8'h00);
        print_char(1'b0, 10'd0, 12'd0, 8'h55, 8'h00);
        print_char(1'b1, 10'd1023, 12'd4095, 8'h00, 8'hFF);
        print_char(1'b0, 10'd0, 12'd0, CHAR_LF, 8'h00);
        print_char(1'b0, 10'd0, 12'd0, 8'h00, 8'h00);
        print_char(1'b1, 10'd238, 12'd4095, 8'h00, 8'hA5);
        print_char(1'b1, 10'd239, 12'd100, 8'h00, 8'h5A);
        print_char(1'b1, 10'd0, 12'd4088, 8'hFF, 8'h3C);
        print_char(1'b1, 10'd5, 12'd7, CHAR_LF, 8'hC3);
        print_char(1'b1, 10'd9, 12'd3, CHAR_CR, 8'h0F);
        print_char(1'b0, 10'd0, 12'd0, 8'h00, 8'h00);

        for (int p = 0; p < 4; p++) begin
            wait_drained();
            case (p)
                0: begin
                    cfg_w = 4'd1;
                    cfg_h = 4'd1;
                    cfg_s = 4'd0;
                end
                1: begin
                    cfg_w = 4'd15;
                    cfg_h = 4'd15;
                    cfg_s = 4'd15;
                end
                2: begin
                    cfg_w = 4'd0;
                    cfg_h = 4'd0;
                    cfg_s = 4'd0;
                end
                default: begin
                    cfg_w = 4'($urandom);
                    cfg_h = 4'($urandom);
                    cfg_s = 4'($urandom);
                end
            endcase
            write_reg(REG_GLYPH_WIDTH, cfg_w);
            write_reg(REG_GLYPH_HEIGHT, cfg_h);
            write_reg(REG_GLYPH_SPACING, cfg_s);
            src_idle   = (p == 1) ? 53 : ((p == 3) ? 10 : 0);
            sink_stall = (p == 2) ? 53 : ((p == 3) ? 10 : 0);
            if (p == 1) begin
                // cursor y pinned at the bottom, then cursor x pinned at its maximum
                print_char(1'b1, 10'd0, 12'd4000, 8'h55, 8'h81);
                repeat (5) print_char(1'b0, 10'd0, 12'd0, CHAR_LF, 8'h00);
                print_char(1'b0, 10'd0, 12'd0, 8'h00, 8'h00);
                print_char(1'b1, 10'd1023, 12'd20, 8'h00, 8'h7E);
                repeat (40) print_char(1'b0, 10'd0, 12'd0, 8'h00, 8'h00);
                print_char(1'b0, 10'd0, 12'd0, CHAR_CR, 8'h00);
                print_char(1'b0, 10'd0, 12'd0, 8'h00, 8'h00);
            end
            random_phase(PHASE_ITEMS);
        end

        wait_drained();
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
